FILE: rtl/ucfb_pkg.sv
package ucfb_pkg;

    localparam int MAX_RESULTS = 10;

    localparam logic [7:0] SYNC_ONE          = 8'hB5;
    localparam logic [7:0] SYNC_TWO          = 8'h62;
    localparam logic [2:0] KEY_BYTES         = 3'd4;
    localparam logic [3:0] FIXED_FRAME_BYTES = 4'd12;

    // Request kinds carried in tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_VERSION   = 2'd0;
    localparam logic [1:0] REG_RESERVED  = 2'd1;
    localparam logic [1:0] REG_VALUE_SET = 2'd2;

    localparam logic [7:0]  VERSION_RST   = 8'd0;
    localparam logic [15:0] RESERVED_RST  = 16'd0;
    localparam logic [7:0]  VALUE_SET_RST = 8'd138;

    typedef struct packed {
        logic [7:0]  version;
        logic [15:0] reserved;
        logic [7:0]  value_set_id;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] payload_count;
        logic [7:0] layer_byte;
        logic [7:0] msg_id;
        logic [7:0] msg_class;
        logic       op;
    } t_item;

    // Result bundle of one item; byte 0 goes out first
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [3:0]                  cnt;
        logic                        frame_end;
        logic                        err;
    } t_bundle;

endpackage

FILE: rtl/ubx_config_frame_builder_top.sv
// Configuration frame builder: turns a stream of requests into framed bytes.
// Input stream (s_axis): tuser = op (0 start, 1 payload byte). A start
// carries class, id, layer and the key+value byte count and produces the
// ten header bytes (sync, class, id, length, version, layer, reserved).
// Each payload request produces its byte; value bytes are dropped unless
// the id equals the value_set_id register. The last payload request also
// produces ck_a and ck_b, ck_b flagged with tlast. A bad start (count below
// four or frame longer than MAX_FRAME_BYTES) produces one zero byte with
// tlast and tuser set. Payload requests with no open frame produce nothing.
// Output stream (m_axis): one byte per beat.
// The first byte of a request goes out through the input register, then
// the result register. Throughput: one request per cycle while each yields
// at most one byte and the output is ready; otherwise input waits while the
// result register shifts out its bytes, one per ready cycle (ten for a start).
// A stalled output holds its byte; the input is held off once both the
// input and the result register are full. Reset clears frame state, empties
// both stages and loads the register defaults. APB registers: 0x0 version,
// 0x4 reserved word, 0x8 value-set id; write only while the block is idle.
module ubx_config_frame_builder_top #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // msg_class[7:0], msg_id[15:8], layer_byte[23:16], payload_count[31:24],
    // data_byte[39:32]
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast,   // frame_end
    output logic        m_axis_tuser    // error_flag
);
    import ucfb_pkg::*;

    t_cfg    r_cfg;
    t_item   w_item;
    t_bundle w_res;
    logic    w_res_vld;
    logic    w_res_rdy;
    logic    w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.version      <= VERSION_RST;
            r_cfg.reserved     <= RESERVED_RST;
            r_cfg.value_set_id <= VALUE_SET_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_VERSION:   r_cfg.version      <= pwdata[7:0];
                REG_RESERVED:  r_cfg.reserved     <= pwdata[15:0];
                REG_VALUE_SET: r_cfg.value_set_id <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_VERSION:   prdata = {24'd0, r_cfg.version};
            REG_RESERVED:  prdata = {16'd0, r_cfg.reserved};
            REG_VALUE_SET: prdata = {24'd0, r_cfg.value_set_id};
            default:       prdata = '0;
        endcase
    end

    assign w_item.op            = s_axis_tuser;
    assign w_item.msg_class     = s_axis_tdata[7:0];
    assign w_item.msg_id        = s_axis_tdata[15:8];
    assign w_item.layer_byte    = s_axis_tdata[23:16];
    assign w_item.payload_count = s_axis_tdata[31:24];
    assign w_item.data_byte     = s_axis_tdata[39:32];

    ucfb_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item_vld (s_axis_tvalid),
        .i_item     (w_item),
        .o_item_rdy (s_axis_tready),
        .i_res_rdy  (w_res_rdy),
        .o_res_vld  (w_res_vld),
        .o_res      (w_res)
    );

    ucfb_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_vld     (w_res_vld),
        .i_res         (w_res),
        .o_res_rdy     (w_res_rdy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: rtl/ucfb_core.sv
module ucfb_core #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ucfb_pkg::t_cfg   i_cfg,
    input  logic             i_item_vld,
    input  ucfb_pkg::t_item  i_item,
    output logic             o_item_rdy,
    input  logic             i_res_rdy,
    output logic             o_res_vld,
    output ucfb_pkg::t_bundle o_res
);
    import ucfb_pkg::*;

    localparam logic [10:0] MAX_LIM = 11'(MAX_FRAME_BYTES);

    logic       r_vld;
    t_item      r_item;
    logic       r_open, n_open;
    logic [7:0] r_left, n_left;
    logic [2:0] r_seen, n_seen;   // key bytes seen, saturates at four
    logic       r_values, n_values;
    logic [7:0] r_sum_a, n_sum_a;
    logic [7:0] r_sum_b, n_sum_b;

    logic       w_step;
    logic       w_match;
    logic [8:0] w_sent;
    logic [8:0] w_len;
    logic       w_reject;
    logic       w_summed;
    logic [7:0] w_pa;
    logic [7:0] w_pb;
    logic [7:0] w_left;
    logic [7:0][7:0] w_hdr;

    assign w_step     = r_vld && i_res_rdy;
    assign o_item_rdy = !r_vld || i_res_rdy;
    assign o_res_vld  = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_item_rdy) begin
            r_vld <= i_item_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item_vld && o_item_rdy) begin
            r_item <= i_item;
        end
    end

    assign w_match  = (r_item.msg_id == i_cfg.value_set_id);
    assign w_sent   = w_match ? {1'b0, r_item.payload_count} : 9'({KEY_BYTES});
    assign w_len    = w_sent + 9'({KEY_BYTES});
    assign w_reject = (r_item.payload_count < 8'({KEY_BYTES}))
                   || ((11'(w_sent) + 11'(FIXED_FRAME_BYTES)) > MAX_LIM);

    // Checksummed header bytes, class through reserved high
    assign w_hdr = {i_cfg.reserved[15:8], i_cfg.reserved[7:0], r_item.layer_byte,
                    i_cfg.version, 7'd0, w_len[8], w_len[7:0],
                    r_item.msg_id, r_item.msg_class};

    assign w_summed = (r_seen < KEY_BYTES) || r_values;
    assign w_pa     = r_sum_a + (w_summed ? r_item.data_byte : 8'd0);
    assign w_pb     = r_sum_b + (w_summed ? w_pa : 8'd0);
    assign w_left   = r_left - 8'd1;

    always_comb begin
        logic [7:0] sa;
        logic [7:0] sb;
        sa       = '0;
        sb       = '0;
        n_open   = r_open;
        n_left   = r_left;
        n_seen   = r_seen;
        n_values = r_values;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        o_res    = '0;
        if (r_item.op == OP_START) begin
            n_open   = 1'b0;
            n_left   = '0;
            n_seen   = '0;
            n_values = 1'b0;
            n_sum_a  = '0;
            n_sum_b  = '0;
            if (w_reject) begin
                o_res.cnt       = 4'd1;
                o_res.frame_end = 1'b1;
                o_res.err       = 1'b1;
            end else begin
                for (int i = 0; i < 8; i++) begin
                    sa = sa + w_hdr[i];
                    sb = sb + sa;
                end
                n_open   = 1'b1;
                n_left   = r_item.payload_count;
                n_values = w_match;
                n_sum_a  = sa;
                n_sum_b  = sb;
                o_res.bytes[0] = SYNC_ONE;
                o_res.bytes[1] = SYNC_TWO;
                for (int i = 0; i < 8; i++) begin
                    o_res.bytes[i+2] = w_hdr[i];
                end
                o_res.cnt = 4'(MAX_RESULTS);
            end
        end else if (r_open) begin
            n_sum_a = w_pa;
            n_sum_b = w_pb;
            n_left  = w_left;
            if (r_seen != KEY_BYTES) begin
                n_seen = r_seen + 3'd1;
            end
            if (w_left == 8'd0) begin
                o_res.frame_end = 1'b1;
                n_open   = 1'b0;
                n_seen   = '0;
                n_values = 1'b0;
                n_sum_a  = '0;
                n_sum_b  = '0;
                if (w_summed) begin
                    o_res.bytes[0] = r_item.data_byte;
                    o_res.bytes[1] = w_pa;
                    o_res.bytes[2] = w_pb;
                    o_res.cnt      = 4'd3;
                end else begin
                    o_res.bytes[0] = w_pa;
                    o_res.bytes[1] = w_pb;
                    o_res.cnt      = 4'd2;
                end
            end else if (w_summed) begin
                o_res.bytes[0] = r_item.data_byte;
                o_res.cnt      = 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_left   <= '0;
            r_seen   <= '0;
            r_values <= 1'b0;
            r_sum_a  <= '0;
            r_sum_b  <= '0;
        end else if (w_step) begin
            r_open   <= n_open;
            r_left   <= n_left;
            r_seen   <= n_seen;
            r_values <= n_values;
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
        end
    end

endmodule

FILE: rtl/ucfb_emit.sv
module ucfb_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_vld,
    input  ucfb_pkg::t_bundle i_res,
    output logic              o_res_rdy,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tlast,
    output logic              m_axis_tuser
);
    import ucfb_pkg::*;

    logic [MAX_RESULTS-1:0][7:0] r_bytes;
    logic [3:0]                  r_left;
    logic                        r_end;
    logic                        r_err;
    logic                        w_take;
    logic                        w_load;

    assign w_take    = (r_left != 4'd0) && m_axis_tready;
    // take a new bundle when empty or while the last byte of the current one leaves
    assign o_res_rdy = (r_left == 4'd0) || ((r_left == 4'd1) && m_axis_tready);
    assign w_load    = i_res_vld && o_res_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (w_load) begin
            r_left <= i_res.cnt;
        end else if (w_take) begin
            r_left <= r_left - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bytes <= i_res.bytes;
            r_end   <= i_res.frame_end;
            r_err   <= i_res.err;
        end else if (w_take) begin
            r_bytes <= {8'h00, r_bytes[MAX_RESULTS-1:1]};
        end
    end

    assign m_axis_tvalid = (r_left != 4'd0);
    assign m_axis_tdata  = r_bytes[0];
    assign m_axis_tlast  = r_end && (r_left == 4'd1);
    assign m_axis_tuser  = r_err && (r_left == 4'd1);

endmodule

FILE: rtl/ucfb_checker.sv
module ucfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // error beat closes its frame and carries a zero byte
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("error beat without tlast or with nonzero data");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

endmodule

bind ubx_config_frame_builder_top ucfb_checker u_ucfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
